// ----- hw/rtl/capacitive_touch_key_detector_top_assert.svh -----
// ----------------------------------------------------------------------------
// touch key detector assertion macros
// shared concurrent assertion forms, clocked on clock and off in reset
// ----------------------------------------------------------------------------
`ifndef CAPACITIVE_TOUCH_KEY_DETECTOR_TOP_ASSERT_SVH
`define CAPACITIVE_TOUCH_KEY_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define CTKD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTKD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ctkd_pkg.sv -----
// ----------------------------------------------------------------------------
// touch key detector package
// fixed widths, field codes and register indexes
// ----------------------------------------------------------------------------
package ctkd_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int SUM_W         = 20;   // sixteen 16-bit samples fit
   localparam int HOLD_W        = 2;
   localparam int TRIM_EACH_END = 2;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 40;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // request kind in tuser
   localparam logic OP_CAL  = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   // result kind in tuser
   localparam logic RK_CAL  = 1'b0;
   localparam logic RK_SCAN = 1'b1;

   // register indexes
   localparam logic CSR_GATE_MARGIN = 1'b0;
   localparam logic CSR_FAULT_LIMIT = 1'b1;

endpackage

// ----- hw/rtl/capacitive_touch_key_detector_top.sv -----
// ----------------------------------------------------------------------------
// capacitive touch key detector
// calibrates an untouched baseline and reports touches per scan group
// ----------------------------------------------------------------------------
// The block takes charge-time samples that were already measured. A
// calibration beat (tuser = 0) is stored; after CAL_SAMPLES of them the
// store is swept one entry a cycle through a single compare/add unit that
// keeps the running sum and the two lowest and two highest values, those
// four are dropped, and a multiply by a fixed reciprocal forms the
// truncated mean as the new baseline. A scan beat (tuser = 1) updates the
// group peak; on the beat with tlast set the peak is tested against
// baseline + gate_margin and 10 * baseline and the holdoff, and a result
// beat goes out. A calibration beat that does not complete a set and a
// scan beat without tlast end in their accept cycle; the beat that completes
// a calibration set passes through the accept cycle, the store sweep with
// its registered read port, two trim steps, the mean step and the emit
// step; a scan beat with tlast passes through accept, test, decide and
// emit. The emit step waits while an earlier result still sits in the
// output register. req_tready is low while an item is in work. The result
// sits in an output register, so a new beat is taken while a result still
// waits; a second result waits for the first to leave. Configuration writes
// are always taken and should only be made while the block is idle.
// ----------------------------------------------------------------------------
module capacitive_touch_key_detector_top
   import ctkd_pkg::*;
#(
   parameter int CAL_SAMPLES   = 10,   // 5 .. 16
   parameter int HOLDOFF_SCANS = 3     // 1 .. 3
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample[15:0], repeat_mode[16], zero pad
   input  logic                  req_tlast,   // last_in_group
   input  logic [0:0]            req_tuser,   // opcode[0]
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // touched[0], baseline_out[16:1],
                                              // peak_out[32:17], calib_fault[33], zero pad
   output logic [0:0]            rsp_tuser,   // result_kind[0]
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [SAMPLE_W-1:0]   csr_data
);

   // sizes that follow from the set length
   localparam int AW       = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
   localparam int IW       = $clog2(CAL_SAMPLES + 1);
   localparam int DIV_N    = CAL_SAMPLES - 2 * TRIM_EACH_END;
   // reciprocal is exact for any sum below 2**20 and a divisor up to 12
   localparam int RECIP_SH = 24;
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam int RECIP    = (2**RECIP_SH + DIV_N - 1) / DIV_N;
   localparam int PROD_W   = SUM_W + RECIP_W;

   // sequencer codes
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SWEEP   = 3'd1;
   localparam logic [2:0] ST_TRIM_LO = 3'd2;
   localparam logic [2:0] ST_TRIM_HI = 3'd3;
   localparam logic [2:0] ST_DIV     = 3'd4;
   localparam logic [2:0] ST_TEST    = 3'd5;
   localparam logic [2:0] ST_DECIDE  = 3'd6;
   localparam logic [2:0] ST_EMIT    = 3'd7;

   // request fields
   sample_type req_sample;
   logic       req_repeat;
   logic       req_fire;
   assign req_sample = req_tdata[SAMPLE_W-1:0];
   assign req_repeat = req_tdata[SAMPLE_W];
   assign req_fire   = req_tvalid && req_tready;

   // calibration store
   sample_type cal_mem [CAL_SAMPLES];
   sample_type rd_data_ff;
   logic       mem_wr_en;
   logic       mem_rd_en;

   // control and datapath registers
   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     cal_cnt_ff, cal_cnt_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;          // running sum of the set
   sample_type        lo1_ff, lo1_in, lo2_ff, lo2_in;
   sample_type        hi1_ff, hi1_in, hi2_ff, hi2_in;
   sample_type        baseline_ff, baseline_in;
   sample_type        group_peak_ff, group_peak_in;
   sample_type        peak_ff, peak_in;
   logic              rep_ff, rep_in;
   logic              gt_ff, gt_in, lt_ff, lt_in;
   logic [HOLD_W-1:0] holdoff_ff, holdoff_in;
   logic              kind_ff, kind_in;
   logic              touch_ff, touch_in;
   sample_type        gate_margin_ff, gate_margin_in;
   sample_type        fault_limit_ff, fault_limit_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_kind_ff, rsp_kind_in;

   // mean by reciprocal multiply
   logic [PROD_W-1:0] mean_prod;

   // scan compare operands
   logic [SAMPLE_W:0]  gate_sum;
   logic [SUM_W-1:0]   ceil_val;
   logic [HOLD_W-1:0]  hold_cur;
   logic               emit_go;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   assign mean_prod = {{RECIP_W{1'b0}}, acc_ff} * {{SUM_W{1'b0}}, RECIP_W'(RECIP)};
   assign gate_sum  = {1'b0, baseline_ff} + {1'b0, gate_margin_ff};
   assign ceil_val  = ({{(SUM_W-SAMPLE_W){1'b0}}, baseline_ff} << 3)
                    + ({{(SUM_W-SAMPLE_W){1'b0}}, baseline_ff} << 1);
   assign hold_cur  = rep_ff ? '0 : holdoff_ff;
   assign emit_go   = !rsp_valid_ff || rsp_tready;

   assign mem_wr_en = req_fire && (req_tuser[0] == OP_CAL);
   assign mem_rd_en = (state_ff == ST_SWEEP) && (idx_ff < IW'(CAL_SAMPLES));

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         cal_mem[cal_cnt_ff] <= req_sample;
      end
      if (mem_rd_en) begin
         rd_data_ff <= cal_mem[idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      state_in       = state_ff;
      cal_cnt_in     = cal_cnt_ff;
      idx_in         = idx_ff;
      rd_vld_in      = 1'b0;
      acc_in         = acc_ff;
      lo1_in         = lo1_ff;
      lo2_in         = lo2_ff;
      hi1_in         = hi1_ff;
      hi2_in         = hi2_ff;
      baseline_in    = baseline_ff;
      group_peak_in  = group_peak_ff;
      peak_in        = peak_ff;
      rep_in         = rep_ff;
      gt_in          = gt_ff;
      lt_in          = lt_ff;
      holdoff_in     = holdoff_ff;
      kind_in        = kind_ff;
      touch_in       = touch_ff;
      gate_margin_in = gate_margin_ff;
      fault_limit_in = fault_limit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_kind_in    = rsp_kind_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index[0])
            CSR_GATE_MARGIN: gate_margin_in = csr_data;
            CSR_FAULT_LIMIT: fault_limit_in = csr_data;
            default:         gate_margin_in = gate_margin_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == OP_CAL) begin
                  if (cal_cnt_ff == AW'(CAL_SAMPLES - 1)) begin
                     // set complete, start the sweep
                     cal_cnt_in = '0;
                     idx_in     = '0;
                     acc_in     = '0;
                     lo1_in     = '1;
                     lo2_in     = '1;
                     hi1_in     = '0;
                     hi2_in     = '0;
                     state_in   = ST_SWEEP;
                  end else begin
                     cal_cnt_in = cal_cnt_ff + 1'b1;
                  end
               end else begin
                  peak_in = (req_sample > group_peak_ff) ? req_sample : group_peak_ff;
                  if (req_tlast) begin
                     group_peak_in = '0;
                     rep_in        = req_repeat;
                     state_in      = ST_TEST;
                  end else begin
                     group_peak_in = peak_in;
                  end
               end
            end
         end
         ST_SWEEP: begin
            if (mem_rd_en) begin
               idx_in    = idx_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               acc_in = acc_ff + {{(SUM_W-SAMPLE_W){1'b0}}, rd_data_ff};
               if (rd_data_ff < lo1_ff) begin
                  lo2_in = lo1_ff;
                  lo1_in = rd_data_ff;
               end else if (rd_data_ff < lo2_ff) begin
                  lo2_in = rd_data_ff;
               end
               if (rd_data_ff > hi1_ff) begin
                  hi2_in = hi1_ff;
                  hi1_in = rd_data_ff;
               end else if (rd_data_ff > hi2_ff) begin
                  hi2_in = rd_data_ff;
               end
               if (!mem_rd_en) begin
                  state_in = ST_TRIM_LO;
               end
            end
         end
         ST_TRIM_LO: begin
            acc_in   = acc_ff - SUM_W'({1'b0, lo1_ff} + {1'b0, lo2_ff});
            state_in = ST_TRIM_HI;
         end
         ST_TRIM_HI: begin
            acc_in   = acc_ff - SUM_W'({1'b0, hi1_ff} + {1'b0, hi2_ff});
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // truncated mean of the kept values
            baseline_in = mean_prod[RECIP_SH +: SAMPLE_W];
            kind_in     = RK_CAL;
            touch_in    = 1'b0;
            peak_in     = '0;
            state_in    = ST_EMIT;
         end
         ST_TEST: begin
            gt_in    = {1'b0, peak_ff} > gate_sum;
            lt_in    = {{(SUM_W-SAMPLE_W){1'b0}}, peak_ff} < ceil_val;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            touch_in   = 1'b0;
            holdoff_in = hold_cur;
            if (gt_ff && lt_ff) begin
               touch_in   = (hold_cur == '0);
               holdoff_in = HOLD_W'(HOLDOFF_SCANS);
            end
            if (holdoff_in != '0) begin
               holdoff_in = holdoff_in - 1'b1;
            end
            kind_in  = RK_SCAN;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_data_in  = {{(RSP_DATA_W-2*SAMPLE_W-2){1'b0}},
                               (baseline_ff > fault_limit_ff),
                               peak_ff, baseline_ff, touch_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cal_cnt_ff     <= '0;
         rd_vld_ff      <= 1'b0;
         baseline_ff    <= '0;
         group_peak_ff  <= '0;
         holdoff_ff     <= '0;
         gate_margin_ff <= SAMPLE_W'(100);
         fault_limit_ff <= SAMPLE_W'(32767);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cal_cnt_ff     <= cal_cnt_in;
         rd_vld_ff      <= rd_vld_in;
         baseline_ff    <= baseline_in;
         group_peak_ff  <= group_peak_in;
         holdoff_ff     <= holdoff_in;
         gate_margin_ff <= gate_margin_in;
         fault_limit_ff <= fault_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      lo1_ff      <= lo1_in;
      lo2_ff      <= lo2_in;
      hi1_ff      <= hi1_in;
      hi2_ff      <= hi2_in;
      peak_ff     <= peak_in;
      rep_ff      <= rep_in;
      gt_ff       <= gt_in;
      lt_ff       <= lt_in;
      kind_ff     <= kind_in;
      touch_ff    <= touch_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

`include "capacitive_touch_key_detector_top_assert.svh"

   // a new result beat only ever comes out of the emit step
   `CTKD_ASSERT_NOW(a_rsp_from_emit, !rsp_valid_ff && rsp_valid_in, state_ff == ST_EMIT, "result loaded outside emit")

   // holdoff is always decremented after a reload
   `CTKD_ASSERT_NOW(a_hold_range, 1'b1, holdoff_ff < HOLD_W'(HOLDOFF_SCANS), "holdoff out of range")

   // no touch can be reported before a nonzero baseline exists
   `CTKD_ASSERT_NOW(a_touch_needs_base, rsp_valid_ff && rsp_kind_ff == RK_SCAN && rsp_data_ff[0], rsp_data_ff[SAMPLE_W:1] != '0, "touch with zero baseline")

   // the emit step always follows straight after the mean step
   `CTKD_ASSERT_NEXT(a_div_ends, state_ff == ST_DIV, state_ff == ST_EMIT, "mean step did not finish")

endmodule

// ----- tb/sv/capacitive_touch_key_detector_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch key detector testbench
// drives calibration and scan beats with bursty gaps, stalls the result side,
// and checks every result beat against a cycle-free prediction of the block
// ----------------------------------------------------------------------------
module capacitive_touch_key_detector_top_test;
   import ctkd_pkg::*;

   localparam int CAL_SET        = 10;     // calibration samples per baseline
   localparam int HOLD_RELOAD    = 3;      // holdoff reload value after a touch
   localparam int SETTLE_CYCLES  = 40;     // idle wait after the last result
   localparam int WATCHDOG_LIMIT = 4000;   // cycles with no beat on any channel
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 205;
   localparam int HALF_PERIOD    = 5;

   // one result beat, unpacked from tuser and tdata
   typedef struct packed {
      logic       kind;
      logic       touched;
      sample_type baseline;
      sample_type peak;
      logic       fault;
   } scan_report_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // sample[15:0], repeat_mode[16], zero pad
   logic                  req_tlast  = 1'b0; // last_in_group
   logic [0:0]            req_tuser  = OP_CAL; // opcode[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // touched[0], baseline_out[16:1],
                                             // peak_out[32:17], calib_fault[33]
   logic [0:0]            rsp_tuser;         // result_kind[0]
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [0:0]            csr_index  = CSR_GATE_MARGIN;
   logic [SAMPLE_W-1:0]   csr_data   = '0;

   // predicted block state
   sample_type   cal_pending [CAL_SET];
   int unsigned  cal_fill    = 0;
   sample_type   base_level  = '0;
   sample_type   run_peak    = '0;
   int unsigned  quiet_scans = 0;
   sample_type   margin_reg  = 16'd100;
   sample_type   limit_reg   = 16'd32767;

   // results predicted but not yet seen, oldest first
   scan_report_type expected_reports [$];

   int unsigned  err_count   = 0;
   int unsigned  burst_left  = 0;
   int unsigned  idle_count  = 0;
   int unsigned  rx_cycle    = 0;
   int unsigned  rx_mode     = 0;

   capacitive_touch_key_detector_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // sort the stored set, drop the two lowest and two highest, average the rest
   function automatic sample_type trimmed_baseline();
      sample_type         v [CAL_SET];
      sample_type         key;
      int                 j;
      logic [SUM_W-1:0]   acc;
      v   = cal_pending;
      acc = '0;
      for (int i = 1; i < CAL_SET; i++) begin
         key = v[i];
         j   = i;
         while (j > 0 && v[j-1] > key) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = key;
      end
      for (int i = TRIM_EACH_END; i < CAL_SET - TRIM_EACH_END; i++)
         acc += v[i];
      return sample_type'(acc / (CAL_SET - 2 * TRIM_EACH_END));
   endfunction

   // advance the predicted state by one accepted request beat
   function automatic void predict_beat(logic op, sample_type smp, logic last, logic rep);
      scan_report_type r;
      sample_type      peak;
      int unsigned     pk;
      int unsigned     bl;
      r = '0;
      if (op == OP_CAL) begin
         // group flags on calibration beats mean nothing
         cal_pending[cal_fill] = smp;
         cal_fill++;
         if (cal_fill == CAL_SET) begin
            cal_fill   = 0;
            base_level = trimmed_baseline();
            r.kind     = RK_CAL;
            r.baseline = base_level;
            r.fault    = (base_level > limit_reg);
            expected_reports.push_back(r);
         end
      end else begin
         peak = (smp > run_peak) ? smp : run_peak;
         if (!last) begin
            run_peak = peak;
         end else begin
            run_peak = '0;
            // repeat mode only counts on the closing beat, before the test
            if (rep)
               quiet_scans = 0;
            pk = peak;
            bl = base_level;
            // wide compares: no wrap on baseline + margin or ten times baseline
            if (pk > bl + margin_reg && pk < 10 * bl) begin
               r.touched   = (quiet_scans == 0);
               quiet_scans = HOLD_RELOAD;
            end
            // the detecting scan itself counts down too
            if (quiet_scans != 0)
               quiet_scans--;
            r.kind     = RK_SCAN;
            r.baseline = base_level;
            r.peak     = peak;
            r.fault    = (base_level > limit_reg);
            expected_reports.push_back(r);
         end
      end
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      err_count++;
   endtask

   // send one request beat; the sender runs in bursts with random gaps between
   task automatic send_beat(logic op, sample_type smp, logic last, logic rep);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         // about half the bursts follow straight on, so long stretches stay dense
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tlast  <= last;
      req_tdata  <= {{(REQ_DATA_W - SAMPLE_W - 1){1'b0}}, rep, smp};
      do @(posedge clock); while (!req_tready);
      predict_beat(op, smp, last, rep);
   endtask

   // hold the sender until every predicted result is in, then let the block go quiet
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(logic [0:0] idx, sample_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_GATE_MARGIN)
         margin_reg = val;
      else
         limit_reg = val;
      @(posedge clock);
   endtask

   function automatic sample_type fit16(int v);
      if (v < 0)
         return '0;
      if (v > 65535)
         return 16'hFFFF;
      return sample_type'(v);
   endfunction

   // scan sample aimed at the interesting spots around the current baseline
   function automatic sample_type scan_pick();
      int b;
      int m;
      int r;
      b = base_level;
      m = margin_reg;
      case ($urandom_range(0, 5))
         0: begin
            r = $urandom_range(0, 100);
            return fit16(b + r - 50);                  // untouched noise
         end
         1: begin
            r = $urandom_range(0, 4 * b + 20);
            return fit16(b + m + 1 + r);               // touch range
         end
         2: begin
            r = $urandom_range(0, 4);
            return fit16(10 * b - 2 + r);              // around the ceiling
         end
         3: begin
            r = $urandom_range(0, 2);
            return fit16(b + m - 1 + r);               // around the margin edge
         end
         default: return sample_type'($urandom_range(0, 65535));
      endcase
   endfunction

   // scan before any calibration: baseline zero, nothing can count as a touch
   task automatic test_scan_before_calibration();
      send_beat(OP_SCAN, 16'hFFFF, 1'b0, 1'b1);
      send_beat(OP_SCAN, 16'h0000, 1'b1, 1'b0);
   endtask

   // extremes on both ends get trimmed; a scan beat sits inside the set and
   // its group keeps its peak across the calibration
   task automatic test_calibration_trim();
      send_beat(OP_CAL,  16'h0000, 1'b1, 1'b1);
      send_beat(OP_CAL,  16'hFFFF, 1'b0, 1'b0);
      send_beat(OP_CAL,  16'd1000, 1'b1, 1'b0);
      send_beat(OP_CAL,  16'd1002, 1'b0, 1'b1);
      send_beat(OP_SCAN, 16'd40,   1'b0, 1'b0);
      send_beat(OP_CAL,  16'd1004, 1'b0, 1'b0);
      send_beat(OP_CAL,  16'd1006, 1'b1, 1'b1);
      send_beat(OP_CAL,  16'd1008, 1'b0, 1'b0);
      send_beat(OP_CAL,  16'd1010, 1'b0, 1'b0);
      send_beat(OP_CAL,  16'hFFFF, 1'b0, 1'b0);
      send_beat(OP_CAL,  16'h0000, 1'b0, 1'b0);
      send_beat(OP_SCAN, 16'd30,   1'b1, 1'b0);
   endtask

   // baseline is 1005 here: touch, muted repeat, repeat mode, both bounds
   task automatic test_touch_and_holdoff();
      send_beat(OP_SCAN, 16'd1200,  1'b1, 1'b0);
      send_beat(OP_SCAN, 16'd1200,  1'b1, 1'b0);
      send_beat(OP_SCAN, 16'd1200,  1'b1, 1'b1);
      send_beat(OP_SCAN, 16'd10050, 1'b1, 1'b1);
      send_beat(OP_SCAN, 16'd1105,  1'b1, 1'b1);
      send_beat(OP_SCAN, 16'd1106,  1'b1, 1'b1);
      send_beat(OP_SCAN, 16'd10049, 1'b1, 1'b1);
   endtask

   // both registers at zero and at full scale
   task automatic test_register_extremes();
      settle_block();
      write_reg(CSR_GATE_MARGIN, 16'h0000);
      write_reg(CSR_FAULT_LIMIT, 16'h0000);
      send_beat(OP_SCAN, 16'd1006, 1'b1, 1'b1);
      settle_block();
      write_reg(CSR_GATE_MARGIN, 16'hFFFF);
      write_reg(CSR_FAULT_LIMIT, 16'hFFFF);
      send_beat(OP_SCAN, 16'd10049, 1'b1, 1'b1);
   endtask

   // mostly whole calibration sets and scan groups with random content,
   // the rest broken sets and loose beats
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      int          center;
      int          spread;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle_block();
         if (ph == 0) begin
            write_reg(CSR_GATE_MARGIN, 16'd100);
            write_reg(CSR_FAULT_LIMIT, 16'd32767);
         end else begin
            case ($urandom_range(0, 3))
               0:       write_reg(CSR_GATE_MARGIN, 16'h0000);
               1:       write_reg(CSR_GATE_MARGIN, 16'hFFFF);
               2:       write_reg(CSR_GATE_MARGIN, sample_type'($urandom_range(0, 2000)));
               default: write_reg(CSR_GATE_MARGIN, sample_type'($urandom_range(0, 65535)));
            endcase
            case ($urandom_range(0, 3))
               0:       write_reg(CSR_FAULT_LIMIT, 16'h0000);
               1:       write_reg(CSR_FAULT_LIMIT, 16'hFFFF);
               2:       write_reg(CSR_FAULT_LIMIT, fit16(int'(base_level) +
                                                         $urandom_range(0, 4) - 2));
               default: write_reg(CSR_FAULT_LIMIT, sample_type'($urandom_range(0, 65535)));
            endcase
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
               // calibration set around a center; some sets are cut short
               case ($urandom_range(0, 3))
                  0: begin center = $urandom_range(0, 60);      spread = 20;    end
                  1: begin center = $urandom_range(200, 3000);  spread = 200;   end
                  2: begin center = $urandom_range(3000, 40000); spread = 5000; end
                  default: begin center = 32768;                 spread = 65535; end
               endcase
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, CAL_SET - 1) : CAL_SET;
               for (int k = 0; k < len; k++) begin
                  if ($urandom_range(0, 7) == 0) begin
                     send_beat(OP_SCAN, scan_pick(), 1'b0, 1'($urandom_range(0, 1)));
                     sent++;
                  end
                  send_beat(OP_CAL, fit16(center + int'($urandom_range(0, 2 * spread)) - spread),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                  sent++;
               end
            end else if (pick < 88) begin
               // scan group, repeat mode set now and then on any beat
               len = $urandom_range(1, 6);
               for (int k = 1; k <= len; k++) begin
                  send_beat(OP_SCAN, scan_pick(), 1'(k == len),
                            1'($urandom_range(0, 9) < 3));
                  sent++;
               end
            end else begin
               send_beat(1'($urandom_range(0, 1)), sample_type'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
      end
   endtask

   // result side: stall pattern is picked anew at random between always ready,
   // coin flip, and ready one cycle in four; every result beat is checked
   always @(posedge clock) begin
      scan_report_type got;
      scan_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind     = rsp_tuser[0];
            got.touched  = rsp_tdata[0];
            got.baseline = rsp_tdata[16:1];
            got.peak     = rsp_tdata[32:17];
            got.fault    = rsp_tdata[33];
            if (expected_reports.size() == 0) begin
               report_mismatch("result with none pending", got, 0);
            end else begin
               want = expected_reports.pop_front();
               if (got.kind !== want.kind)
                  report_mismatch("result_kind", got.kind, want.kind);
               if (got.touched !== want.touched)
                  report_mismatch("touched", got.touched, want.touched);
               if (got.baseline !== want.baseline)
                  report_mismatch("baseline_out", got.baseline, want.baseline);
               if (got.peak !== want.peak)
                  report_mismatch("peak_out", got.peak, want.peak);
               if (got.fault !== want.fault)
                  report_mismatch("calib_fault", got.fault, want.fault);
            end
         end
         rx_cycle++;
         if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 2);
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= (rx_cycle % 4 == 0);
         endcase
      end
   end

   // watchdog: too long with no beat on any channel means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_count = 0;
      else
         idle_count++;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_scan_before_calibration();
      test_calibration_trim();
      test_touch_and_holdoff();
      test_register_extremes();
      test_random_traffic();
      settle_block();
      if (err_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- capacitive_touch_key_detector_top.f -----
+incdir+hw/rtl
hw/rtl/ctkd_pkg.sv
hw/rtl/capacitive_touch_key_detector_top.sv
tb/sv/capacitive_touch_key_detector_top_test.sv
